// ===== rtl/pileup_allele_counter_core_assert.svh =====
// Assertion macros for the RTL modules; pac_ctrl includes them.
`ifndef PILEUP_ALLELE_COUNTER_CORE_ASSERT_SVH
`define PILEUP_ALLELE_COUNTER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PAC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pileup allele counter assertion failed");

// Check that cons holds in the cycle after ante.
`define PAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pileup allele counter assertion failed");

`endif

// ===== rtl/pac_pkg.sv =====
package pac_pkg;

   localparam int BASE_BITS        = 8;
   localparam int NUM_BINS         = 256;
   localparam int BIN_BITS         = $clog2(NUM_BINS);
   localparam int DEF_COUNT_BITS   = 16;
   localparam int FIELD_COUNT_BITS = 16;
   localparam int OTHER_BITS       = 24;

   localparam logic [BASE_BITS-1:0] CHAR_N       = 8'd78;
   localparam logic [BASE_BITS-1:0] CHAR_DOT     = 8'd46;
   localparam logic [BASE_BITS-1:0] CHAR_LOWER_A = 8'd97;
   localparam logic [BASE_BITS-1:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [BASE_BITS-1:0] CASE_OFFSET  = 8'd32;

   localparam logic KIND_BASE   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load_base;
      logic                load_finish;
      logic [BIN_BITS-1:0] walk_addr;
      logic                inc;
      logic                acc;
      logic                emit;
   } pac_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_kind;
      logic req_is_n;
      logic req_single;
      logic rsp_free;
   } pac_stat_type;

   // Map a..z to A..Z, leave other codes alone.
   function automatic logic [BASE_BITS-1:0] to_upper(input logic [BASE_BITS-1:0] c);
      logic [BASE_BITS-1:0] r;
      r = c;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

// ===== rtl/pac_req_if.sv =====
interface pac_req_if;
   import pac_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic [BASE_BITS-1:0] base;
   logic [BASE_BITS-1:0] ref_code;
   logic                 ref_is_single;

   modport source (output valid, kind, base, ref_code, ref_is_single, input ready);
   modport sink (input valid, kind, base, ref_code, ref_is_single, output ready);
endinterface

// ===== rtl/pac_rsp_if.sv =====
interface pac_rsp_if;
   import pac_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [FIELD_COUNT_BITS-1:0] ref_depth;
   logic [BASE_BITS-1:0]        alt_code;
   logic                        alt_found;
   logic [FIELD_COUNT_BITS-1:0] alt_depth;
   logic [OTHER_BITS-1:0]       rest_depth;
   logic                        not_snp;

   modport source (output valid, ref_depth, alt_code, alt_found, alt_depth, rest_depth,
                   not_snp, input ready);
   modport sink (input valid, ref_depth, alt_code, alt_found, alt_depth, rest_depth,
                 not_snp, output ready);
endinterface

// ===== rtl/pileup_allele_counter_core.sv =====
// Base request: read the bin, then write it back; the next request is taken after the write.
// An uppercase N is dropped and the block stays ready. Finish request: one pass over the 256
// bins through the single memory read port; when the output register is free the result is
// loaded into it (without the pass if not single), and only then is the next request taken.
// A finished result waits in the output register while base requests go on. Synchronous
// active-high reset clears control state, the output valid and all bin valid bits.
module pileup_allele_counter_core #(
   parameter int COUNT_BITS = pac_pkg::DEF_COUNT_BITS
) (
   input logic        clock,
   input logic        reset,
   pac_req_if.sink    req_ch,
   pac_rsp_if.source  rsp_ch
);
   import pac_pkg::*;

   pac_cmd_type  cmd;
   pac_stat_type stat;

   // Sequence requests and the histogram walk.
   pac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the histogram, scan it and form the result.
   pac_dp #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_ch.kind),
      .req_base          (req_ch.base),
      .req_ref_code      (req_ch.ref_code),
      .req_ref_is_single (req_ch.ref_is_single),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ref_depth     (rsp_ch.ref_depth),
      .rsp_alt_code      (rsp_ch.alt_code),
      .rsp_alt_found     (rsp_ch.alt_found),
      .rsp_alt_depth     (rsp_ch.alt_depth),
      .rsp_rest_depth    (rsp_ch.rest_depth),
      .rsp_not_snp       (rsp_ch.not_snp)
   );
endmodule

// ===== rtl/pac_ctrl.sv =====
module pac_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pac_pkg::pac_stat_type stat,
   output pac_pkg::pac_cmd_type  cmd
);
   import pac_pkg::*;
   `include "pileup_allele_counter_core_assert.svh"

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_INC  = 3'd1;
   localparam logic [2:0] S_WALK = 3'd2;
   localparam logic [2:0] S_TAIL = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [BIN_BITS-1:0] cnt_ff, cnt_in;
   logic                accept;

   // Sequence base updates and the histogram walk.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd           = '0;
      cmd.walk_addr = cnt_ff;
      req_ready     = (state_ff == S_IDLE);
      accept        = req_valid && req_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (stat.req_kind == KIND_FINISH) begin
                  cmd.load_finish = 1'b1;
                  cnt_in          = '0;
                  state_in        = stat.req_single ? S_WALK : S_EMIT;
               end else if (!stat.req_is_n) begin
                  cmd.load_base = 1'b1;
                  state_in      = S_INC;
               end
            end
         end
         S_INC: begin
            cmd.inc  = 1'b1;
            state_in = S_IDLE;
         end
         S_WALK: begin
            cmd.acc = (cnt_ff != '0);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            cmd.acc  = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance state and walk counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   `PAC_ASSERT_SAME(a_emit_slot_free, clock, reset, cmd.emit, stat.rsp_free)
   `PAC_ASSERT_NEXT(a_walk_ends, clock, reset, state_ff == S_WALK && cnt_ff == '1, state_ff == S_TAIL)
   `PAC_ASSERT_NEXT(a_tail_to_emit, clock, reset, state_ff == S_TAIL, state_ff == S_EMIT)
   `PAC_ASSERT_NEXT(a_base_updates, clock, reset, cmd.load_base, state_ff == S_INC && cmd.inc)
endmodule

// ===== rtl/pac_dp.sv =====
module pac_dp #(
   parameter int COUNT_BITS = pac_pkg::DEF_COUNT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pac_pkg::pac_cmd_type                 cmd,
   output pac_pkg::pac_stat_type                stat,
   input  logic                                 req_kind,
   input  logic [pac_pkg::BASE_BITS-1:0]        req_base,
   input  logic [pac_pkg::BASE_BITS-1:0]        req_ref_code,
   input  logic                                 req_ref_is_single,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [pac_pkg::FIELD_COUNT_BITS-1:0] rsp_ref_depth,
   output logic [pac_pkg::BASE_BITS-1:0]        rsp_alt_code,
   output logic                                 rsp_alt_found,
   output logic [pac_pkg::FIELD_COUNT_BITS-1:0] rsp_alt_depth,
   output logic [pac_pkg::OTHER_BITS-1:0]       rsp_rest_depth,
   output logic                                 rsp_not_snp
);
   import pac_pkg::*;

   localparam int SUM_BITS   = COUNT_BITS + BIN_BITS;
   localparam int OWIDE_BITS = (SUM_BITS > OTHER_BITS) ? SUM_BITS : OTHER_BITS;
   localparam int CWIDE_BITS = (COUNT_BITS > FIELD_COUNT_BITS) ? COUNT_BITS : FIELD_COUNT_BITS;
   localparam logic [OTHER_BITS-1:0]       OTHER_MAX = '1;
   localparam logic [FIELD_COUNT_BITS-1:0] FIELD_MAX = '1;

   logic [COUNT_BITS-1:0] hist_mem [NUM_BINS];
   logic [NUM_BINS-1:0]   vld_ff;
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  hit_ff;
   logic [BIN_BITS-1:0]   rd_addr, rd_addr_ff;
   logic [BIN_BITS-1:0]   bin_ff;
   logic [BASE_BITS-1:0]  refb_ff;
   logic                  single_ff;
   logic [BASE_BITS-1:0]  best_ff;
   logic [COUNT_BITS-1:0] best_cnt_ff;
   logic [COUNT_BITS-1:0] ref_cnt_ff;
   logic [SUM_BITS-1:0]   sum_ff;
   logic                  rsp_valid_ff;
   logic [BASE_BITS-1:0]  req_upper;
   logic [COUNT_BITS-1:0] bin_val, inc_val;
   logic [SUM_BITS-1:0]   others;
   logic [OWIDE_BITS-1:0] others_wide;
   logic [CWIDE_BITS-1:0] ref_wide, alt_wide;
   logic [OTHER_BITS-1:0]       other_sat;
   logic [FIELD_COUNT_BITS-1:0] ref_sat, alt_sat;

   // Pick the read address: the incoming base's bin or the walk position.
   always_comb begin
      req_upper = to_upper(req_base);
      rd_addr   = cmd.load_base ? req_upper[BIN_BITS-1:0] : cmd.walk_addr;
      bin_val   = hit_ff ? rd_data_ff : '0;
      inc_val   = (bin_val == '1) ? bin_val : bin_val + 1'b1;
   end

   // Histogram storage with registered read.
   always_ff @(posedge clock) begin
      if (cmd.inc) begin
         hist_mem[bin_ff] <= inc_val;
      end
      rd_data_ff <= hist_mem[rd_addr];
   end

   // Track written bins; drop all of them at each result.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.emit) begin
         vld_ff <= '0;
      end else if (cmd.inc) begin
         vld_ff[bin_ff] <= 1'b1;
      end
   end

   // Hold the read address and its valid bit beside the read data.
   always_ff @(posedge clock) begin
      hit_ff     <= vld_ff[rd_addr];
      rd_addr_ff <= rd_addr;
      if (cmd.load_base) begin
         bin_ff <= req_upper[BIN_BITS-1:0];
      end
   end

   // Scan bins: capture the reference, keep the best, sum the rest.
   always_ff @(posedge clock) begin
      if (cmd.load_finish) begin
         refb_ff     <= to_upper(req_ref_code);
         single_ff   <= req_ref_is_single;
         best_ff     <= CHAR_DOT;
         best_cnt_ff <= '0;
         ref_cnt_ff  <= '0;
         sum_ff      <= '0;
      end else if (cmd.acc) begin
         if (rd_addr_ff == refb_ff[BIN_BITS-1:0]) begin
            ref_cnt_ff <= bin_val;
         end else begin
            sum_ff <= sum_ff + SUM_BITS'(bin_val);
            if (bin_val > best_cnt_ff) begin
               best_cnt_ff <= bin_val;
               best_ff     <= BASE_BITS'(rd_addr_ff);
            end
         end
      end
   end

   // Saturate the totals to the result field widths.
   always_comb begin
      others      = sum_ff - SUM_BITS'(best_cnt_ff);
      others_wide = OWIDE_BITS'(others);
      other_sat   = (others_wide > OWIDE_BITS'(OTHER_MAX)) ? OTHER_MAX
                                                           : others_wide[OTHER_BITS-1:0];
      ref_wide    = CWIDE_BITS'(ref_cnt_ff);
      alt_wide    = CWIDE_BITS'(best_cnt_ff);
      ref_sat     = (ref_wide > CWIDE_BITS'(FIELD_MAX)) ? FIELD_MAX
                                                        : ref_wide[FIELD_COUNT_BITS-1:0];
      alt_sat     = (alt_wide > CWIDE_BITS'(FIELD_MAX)) ? FIELD_MAX
                                                        : alt_wide[FIELD_COUNT_BITS-1:0];
   end

   // Load the output register; hold it until the result is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (single_ff) begin
            rsp_ref_depth  <= ref_sat;
            rsp_alt_code   <= best_ff;
            rsp_alt_found  <= (best_cnt_ff != '0);
            rsp_alt_depth  <= alt_sat;
            rsp_rest_depth <= other_sat;
            rsp_not_snp    <= 1'b0;
         end else begin
            rsp_ref_depth  <= '0;
            rsp_alt_code   <= CHAR_DOT;
            rsp_alt_found  <= 1'b0;
            rsp_alt_depth  <= '0;
            rsp_rest_depth <= '0;
            rsp_not_snp    <= 1'b1;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign stat.req_kind   = req_kind;
   assign stat.req_is_n   = (req_base == CHAR_N);
   assign stat.req_single = req_ref_is_single;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;
endmodule

// ===== tb/tb_pileup_allele_counter_core.sv =====
`timescale 1ns / 1ps

module tb_pileup_allele_counter_core;
   import pac_pkg::*;

   localparam int COUNT_W      = DEF_COUNT_BITS;
   localparam int STALL_LIMIT  = 4000;
   localparam int TAIL_CYCLES  = 300;
   localparam longint FIELD_MAX = (64'd1 << FIELD_COUNT_BITS) - 1;
   localparam longint OTHER_MAX = (64'd1 << OTHER_BITS) - 1;

   // One position call as the block reports it.
   typedef struct packed {
      logic [FIELD_COUNT_BITS-1:0] ref_depth;
      logic [BASE_BITS-1:0]        alt_code;
      logic                        alt_found;
      logic [FIELD_COUNT_BITS-1:0] alt_depth;
      logic [OTHER_BITS-1:0]       rest_depth;
      logic                        not_snp;
   } allele_call_type;

   // Base histogram tally and the queue of calls it predicts.
   class call_scoreboard_type;
      logic [COUNT_W-1:0] tally_bins [NUM_BINS];
      allele_call_type    pending_calls [$];
      int unsigned        errors;
      int unsigned        calls_checked;
      int unsigned        finishes_seen;

      function new();
         clear_bins();
         errors        = 0;
         calls_checked = 0;
         finishes_seen = 0;
      endfunction

      function void clear_bins();
         foreach (tally_bins[i]) tally_bins[i] = '0;
      endfunction

      function logic [BASE_BITS-1:0] fold_case(input logic [BASE_BITS-1:0] c);
         return (c >= "a" && c <= "z") ? c - 8'd32 : c;
      endfunction

      // Count a base, or close the position and predict its call.
      function void note_request(input logic kind, input logic [BASE_BITS-1:0] base,
                                 input logic [BASE_BITS-1:0] ref_b, input logic single);
         logic [BASE_BITS-1:0] slot;
         logic [BASE_BITS-1:0] ref_u;
         logic [BASE_BITS-1:0] best;
         logic [COUNT_W-1:0]   best_n;
         longint               others;
         int                   i;
         allele_call_type      call;
         if (kind == KIND_BASE) begin
            if (base != CHAR_N) begin
               slot = fold_case(base);
               if (tally_bins[slot] != '1) tally_bins[slot] = tally_bins[slot] + 1'b1;
            end
            return;
         end
         finishes_seen++;
         call          = '0;
         call.alt_code = CHAR_DOT;
         if (!single) begin
            call.not_snp = 1'b1;
         end else begin
            ref_u  = fold_case(ref_b);
            best   = CHAR_DOT;
            best_n = '0;
            // strict compare keeps the lowest code on a tie
            for (i = 0; i < NUM_BINS; i++) begin
               if (i != ref_u && tally_bins[i] > best_n) begin
                  best_n = tally_bins[i];
                  best   = i[BASE_BITS-1:0];
               end
            end
            others = 0;
            for (i = 0; i < NUM_BINS; i++) begin
               if (i != ref_u && !(best_n != 0 && i == best)) others += tally_bins[i];
            end
            call.ref_depth  = FIELD_COUNT_BITS'((tally_bins[ref_u] > FIELD_MAX) ?
                                                FIELD_MAX : longint'(tally_bins[ref_u]));
            call.alt_code   = (best_n != 0) ? best : CHAR_DOT;
            call.alt_found  = (best_n != 0);
            call.alt_depth  = FIELD_COUNT_BITS'((best_n > FIELD_MAX) ?
                                                FIELD_MAX : longint'(best_n));
            call.rest_depth = OTHER_BITS'((others > OTHER_MAX) ? OTHER_MAX : others);
         end
         pending_calls.push_back(call);
         clear_bins();
      endfunction

      function void report(input string field, input logic [31:0] want,
                           input logic [31:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                  $time, field, want, want, got, got);
      endfunction

      // Compare a result with the oldest predicted call.
      function void check_result(input allele_call_type got);
         allele_call_type want;
         if (pending_calls.size() == 0) begin
            errors++;
            $display("%0t: expected no result, actual %p", $time, got);
            return;
         end
         want = pending_calls.pop_front();
         calls_checked++;
         if (got.ref_depth !== want.ref_depth)
            report("ref_depth", 32'(want.ref_depth), 32'(got.ref_depth));
         if (got.alt_code !== want.alt_code)
            report("alt_code", 32'(want.alt_code), 32'(got.alt_code));
         if (got.alt_found !== want.alt_found)
            report("alt_found", 32'(want.alt_found), 32'(got.alt_found));
         if (got.alt_depth !== want.alt_depth)
            report("alt_depth", 32'(want.alt_depth), 32'(got.alt_depth));
         if (got.rest_depth !== want.rest_depth)
            report("rest_depth", 32'(want.rest_depth), 32'(got.rest_depth));
         if (got.not_snp !== want.not_snp)
            report("not_snp", 32'(want.not_snp), 32'(got.not_snp));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   requests_sent;
   int   stall_cycles = 0;
   allele_call_type     seen_call;
   call_scoreboard_type tally = new();

   pac_req_if req ();
   pac_rsp_if rsp ();

   pileup_allele_counter_core #(
      .COUNT_BITS(COUNT_W)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req),
      .rsp_ch(rsp)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Randomly hold off the result channel.
   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Sample both handshakes; check results before noting new requests.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            seen_call.ref_depth  = rsp.ref_depth;
            seen_call.alt_code   = rsp.alt_code;
            seen_call.alt_found  = rsp.alt_found;
            seen_call.alt_depth  = rsp.alt_depth;
            seen_call.rest_depth = rsp.rest_depth;
            seen_call.not_snp    = rsp.not_snp;
            tally.check_result(seen_call);
         end
         if (req.valid && req.ready)
            tally.note_request(req.kind, req.base, req.ref_code, req.ref_is_single);
      end
   end

   // Abort when nothing moves for too long.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("[pileup_allele_counter_core] ERROR");
            $finish;
         end
      end
   end

   // Present one request and hold it until accepted; called at a falling edge.
   task automatic send_request(input logic kind, input logic [BASE_BITS-1:0] base,
                               input logic [BASE_BITS-1:0] ref_b, input logic single);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid         <= 1'b1;
      req.kind          <= kind;
      req.base          <= base;
      req.ref_code      <= ref_b;
      req.ref_is_single <= single;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   // Unused fields carry random values.
   task automatic push_base(input logic [BASE_BITS-1:0] b);
      send_request(KIND_BASE, b, BASE_BITS'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   task automatic push_finish(input logic [BASE_BITS-1:0] r, input logic single);
      send_request(KIND_FINISH, BASE_BITS'($urandom_range(255)), r, single);
   endtask

   function automatic logic [BASE_BITS-1:0] any_nucleotide();
      string letters;
      letters = "ACGTacgt";
      return letters[$urandom_range(7)];
   endfunction

   // Mostly realistic reads around a major and a minor allele, plus noise codes.
   function automatic logic [BASE_BITS-1:0] pick_base(input logic [BASE_BITS-1:0] major,
                                                      input logic [BASE_BITS-1:0] minor);
      string marks;
      int    r;
      marks = "*.,+-";
      r     = $urandom_range(99);
      if (r < 45) return $urandom_range(1) ? major : major | 8'h20;
      if (r < 65) return $urandom_range(1) ? minor : minor | 8'h20;
      if (r < 80) return any_nucleotide();
      if (r < 88) return $urandom_range(1) ? CHAR_N : CHAR_N | 8'h20;
      if (r < 94) return marks[$urandom_range(4)];
      return BASE_BITS'($urandom_range(255));
   endfunction

   // Random pileups until the request count reaches the target.
   task automatic run_pileups(input int target);
      logic [BASE_BITS-1:0] major;
      logic [BASE_BITS-1:0] minor;
      logic [BASE_BITS-1:0] ref_b;
      int                   depth;
      int                   r;
      int                   k;
      while (requests_sent < target) begin
         major = any_nucleotide() & 8'hDF;
         minor = any_nucleotide() & 8'hDF;
         r     = $urandom_range(99);
         depth = (r < 70) ? $urandom_range(12) :
                 (r < 95) ? $urandom_range(40) : $urandom_range(120);
         for (k = 0; k < depth; k++) push_base(pick_base(major, minor));
         r     = $urandom_range(99);
         ref_b = (r < 30) ? major : (r < 85) ? any_nucleotide() :
                 BASE_BITS'($urandom_range(255));
         push_finish(ref_b, $urandom_range(99) < 90);
      end
   endtask

   initial begin
      reset             = 1'b1;
      req.valid         = 1'b0;
      req.kind          = KIND_BASE;
      req.base          = '0;
      req.ref_code      = '0;
      req.ref_is_single = 1'b0;
      requests_sent     = 0;
      send_idle_pct     = 12;
      recv_idle_pct     = 72;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty position
      push_finish("A", 1'b1);
      // non-single reference discards counts, then the histogram must be empty
      push_base("C");
      push_base("t");
      push_finish("A", 1'b0);
      push_finish("C", 1'b1);
      // case folding, N skipped, lowercase n counted in the N bin
      push_base("a");
      push_base("A");
      push_base("g");
      push_base("G");
      push_base("g");
      push_base("n");
      push_base(CHAR_N);
      push_finish("a", 1'b1);
      // tie goes to the lower code
      push_base("T");
      push_base("C");
      push_finish("G", 1'b1);
      // extreme codes
      push_base(8'h00);
      push_base(8'hFF);
      push_base(8'h7F);
      push_finish(8'hFF, 1'b1);
      push_base(8'h00);
      push_base(8'h00);
      push_base(8'hFF);
      push_finish(8'h00, 1'b1);

      run_pileups(150);
      send_idle_pct = 72;
      recv_idle_pct = 12;
      run_pileups(300);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_pileups(430);
      req.valid <= 1'b0;

      // drain, then let any late result show up
      while (tally.pending_calls.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tally.pending_calls.size() != 0) begin
         tally.errors++;
         $display("%0t: %0d calls never reported", $time, tally.pending_calls.size());
      end

      $display("Sent %0d requests over %0d positions, %0d calls checked, %0d errors.",
               requests_sent, tally.finishes_seen, tally.calls_checked, tally.errors);
      $display("Covered empty, non-single, tie, case-fold and extreme-code positions, %s",
               "then random pileups under three stall mixes.");
      if (tally.errors == 0) begin
         $display("[pileup_allele_counter_core] OK");
      end else begin
         $display("[pileup_allele_counter_core] ERROR");
      end
      $finish;
   end

endmodule
